// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the receiver RTL.
// Depends on a clock named clk_i and an active-low reset named rst_ni in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define SWARQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every clock edge, reset included.
`define SWARQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/swarq_pkg.sv =====
// Package for the sliding-window ARQ receiver: field widths, codes and shared types.
// No dependencies.
package swarq_pkg;

  localparam int unsigned SEQ_SPACE_DEF = 8;
  localparam int unsigned WINDOW_DEF    = 4;

  localparam int unsigned SEQ_W    = 3;
  localparam int unsigned NUM_W    = 3;
  localparam int unsigned NOW_W    = 3;
  localparam int unsigned TOTAL_W  = 16;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 16'hFFFF;
  localparam logic [NOW_W-1:0]   NOW_MAX   = 3'd7;

  typedef enum logic {
    KIND_ACK = 1'b0,
    KIND_NAK = 1'b1
  } reply_kind_e;

  typedef enum logic [1:0] {
    OUTCOME_DELIVERED = 2'd0,
    OUTCOME_BUFFERED  = 2'd1,
    OUTCOME_DISCARDED = 2'd2
  } outcome_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_WALK,
    ST_REPLY
  } state_e;

  typedef struct packed {
    logic wr_en;
    logic wr_data;
    logic rd_en;
  } mark_cmd_t;

endpackage

// ===== rtl/core/swarq_if.sv =====
// Request channel interfaces of the receiver: arriving frames and reply frames.
// Depends on swarq_pkg for the field widths.
interface swarq_frame_if;
  import swarq_pkg::*;

  logic             valid;
  logic             ready;
  logic [SEQ_W-1:0] frame_seq;

  modport source (output valid, output frame_seq, input ready);
  modport sink (input valid, input frame_seq, output ready);
endinterface

interface swarq_reply_if;
  import swarq_pkg::*;

  logic               valid;
  logic               ready;
  logic               reply_kind;
  logic [NUM_W-1:0]   reply_number;
  logic [1:0]         arrival_outcome;
  logic [NOW_W-1:0]   delivered_now;
  logic [TOTAL_W-1:0] total_delivered;

  modport source (
    output valid, output reply_kind, output reply_number, output arrival_outcome,
    output delivered_now, output total_delivered, input ready
  );
  modport sink (
    input valid, input reply_kind, input reply_number, input arrival_outcome,
    input delivered_now, input total_delivered, output ready
  );
endinterface

// ===== rtl/core/sliding_window_arq_receiver.sv =====
// Sliding-window ARQ receiver: a taken frame passes the lookup state, in selective repeat mode
// a walk over buffered marks, and the reply state, which loads the reply request register.
// A new frame is taken only back in the idle state after that load; a reply still waiting for the sink delays it.
// Reset makes the expected number and delivered count zero, clears all marks through
// per-entry valid flags, and selects go-back-n mode.
// Depends on swarq_pkg, swarq_if, swarq_mark_mem and swarq_ctrl.
module sliding_window_arq_receiver #(
  parameter int unsigned SEQ_SPACE = swarq_pkg::SEQ_SPACE_DEF,
  parameter int unsigned WINDOW    = swarq_pkg::WINDOW_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          receive_mode_we_i,
  input  logic          receive_mode_i,
  swarq_frame_if.sink   frame_i,
  swarq_reply_if.source reply_o
);
  import swarq_pkg::*;

  localparam int unsigned AddrW = $clog2(SEQ_SPACE);

  logic             mode_q;
  mark_cmd_t        buf_cmd;
  mark_cmd_t        nak_cmd;
  logic [AddrW-1:0] buf_waddr;
  logic [AddrW-1:0] buf_raddr;
  logic [AddrW-1:0] nak_addr;
  logic             buf_rdata;
  logic             nak_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (receive_mode_we_i) begin
      mode_q <= receive_mode_i;
    end
  end

  swarq_ctrl #(
    .SEQ_SPACE (SEQ_SPACE),
    .WINDOW    (WINDOW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .receive_mode_i (mode_q),
    .frame_i        (frame_i),
    .reply_o        (reply_o),
    .buf_cmd_o      (buf_cmd),
    .buf_waddr_o    (buf_waddr),
    .buf_raddr_o    (buf_raddr),
    .buf_rdata_i    (buf_rdata),
    .nak_cmd_o      (nak_cmd),
    .nak_addr_o     (nak_addr),
    .nak_rdata_i    (nak_rdata)
  );

  swarq_mark_mem #(
    .DEPTH (SEQ_SPACE)
  ) u_buf_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (buf_cmd),
    .waddr_i (buf_waddr),
    .raddr_i (buf_raddr),
    .rdata_o (buf_rdata)
  );

  swarq_mark_mem #(
    .DEPTH (SEQ_SPACE)
  ) u_nak_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (nak_cmd),
    .waddr_i (nak_addr),
    .raddr_i (nak_addr),
    .rdata_o (nak_rdata)
  );

endmodule

// ===== rtl/core/swarq_mark_mem.sv =====
// One-bit mark memory with registered read data and per-entry valid flags.
// Depends on swarq_pkg for the command struct; unwritten entries read as zero.
module swarq_mark_mem #(
  parameter int unsigned DEPTH = swarq_pkg::SEQ_SPACE_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  swarq_pkg::mark_cmd_t     cmd_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic                     rdata_o
);
  import swarq_pkg::*;

  logic             mem_q [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic             rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[waddr_i] <= cmd_i.wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (cmd_i.wr_en) begin
      vld_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[raddr_i] & vld_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/swarq_ctrl.sv =====
// Receive sequencer: window state, mark memory accesses, reply register.
// Depends on swarq_pkg, swarq_if and assert_macros.svh.
`include "assert_macros.svh"

module swarq_ctrl #(
  parameter int unsigned SEQ_SPACE = swarq_pkg::SEQ_SPACE_DEF,
  parameter int unsigned WINDOW    = swarq_pkg::WINDOW_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         receive_mode_i,
  swarq_frame_if.sink                  frame_i,
  swarq_reply_if.source                reply_o,
  output swarq_pkg::mark_cmd_t         buf_cmd_o,
  output logic [$clog2(SEQ_SPACE)-1:0] buf_waddr_o,
  output logic [$clog2(SEQ_SPACE)-1:0] buf_raddr_o,
  input  logic                         buf_rdata_i,
  output swarq_pkg::mark_cmd_t         nak_cmd_o,
  output logic [$clog2(SEQ_SPACE)-1:0] nak_addr_o,
  input  logic                         nak_rdata_i
);
  import swarq_pkg::*;

  localparam int unsigned SeqW  = $clog2(SEQ_SPACE);
  localparam int unsigned DistW = SeqW + 1;
  localparam int unsigned NowW  = $clog2(WINDOW + 1);
  localparam int unsigned Span  = WINDOW % SEQ_SPACE;
  localparam bit          MultiWin = (WINDOW > 1);

  state_e             state_q, state_d;
  logic [SEQ_W-1:0]   seq_q, seq_d;
  logic               sr_q, sr_d;
  logic [SeqW-1:0]    exp_q, exp_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic [NowW-1:0]    now_q, now_d;
  reply_kind_e        kind_q, kind_d;
  outcome_e           outc_q, outc_d;

  logic               rvalid_q, rvalid_d;
  reply_kind_e        rkind_q, rkind_d;
  logic [NUM_W-1:0]   rnum_q, rnum_d;
  outcome_e           routc_q, routc_d;
  logic [NOW_W-1:0]   rnow_q, rnow_d;
  logic [TOTAL_W-1:0] rtotal_q, rtotal_d;

  logic               accept;
  logic               in_range;
  logic [SeqW-1:0]    seq_idx;
  logic               match;
  logic [DistW-1:0]   ahead;
  logic               in_window;
  logic [SeqW-1:0]    exp_next;
  logic [SeqW-1:0]    ack_num;
  logic [TOTAL_W-1:0] total_inc;
  logic               walk_more;
  logic               reply_load;

  assign accept    = frame_i.valid && (state_q == ST_IDLE);
  assign in_range  = (32'(seq_q) < SEQ_SPACE);
  assign seq_idx   = SeqW'(seq_q);
  assign match     = in_range && (seq_idx == exp_q);
  assign ahead     = (seq_idx >= exp_q)
                   ? (DistW'(seq_idx) - DistW'(exp_q))
                   : (DistW'(seq_idx) + DistW'(SEQ_SPACE) - DistW'(exp_q));
  assign in_window = sr_q && in_range && (32'(ahead) < Span);
  assign exp_next  = (exp_q == SeqW'(SEQ_SPACE - 1)) ? '0 : exp_q + 1'b1;
  assign ack_num   = (exp_q == '0) ? SeqW'(SEQ_SPACE - 1) : exp_q - 1'b1;
  assign total_inc = (total_q == TOTAL_MAX) ? total_q : total_q + 1'b1;
  assign walk_more = (32'(now_q) + 32'd1 < WINDOW);
  assign reply_load = (state_q == ST_REPLY) && (!rvalid_q || reply_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (match && sr_q && MultiWin) begin
          state_d = ST_WALK;
        end else begin
          state_d = ST_REPLY;
        end
      end
      ST_WALK: begin
        if (!(buf_rdata_i && walk_more)) begin
          state_d = ST_REPLY;
        end
      end
      ST_REPLY: begin
        if (reply_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    seq_d     = seq_q;
    sr_d      = sr_q;
    exp_d     = exp_q;
    total_d   = total_q;
    now_d     = now_q;
    kind_d    = kind_q;
    outc_d    = outc_q;
    buf_cmd_o = '0;
    nak_cmd_o = '0;
    buf_waddr_o = exp_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          seq_d = frame_i.frame_seq;
          sr_d  = receive_mode_i;
          nak_cmd_o.rd_en = 1'b1;
        end
      end
      ST_LOOKUP: begin
        kind_d = KIND_ACK;
        now_d  = '0;
        if (match) begin
          buf_cmd_o.wr_en = 1'b1;
          nak_cmd_o.wr_en = 1'b1;
          buf_cmd_o.rd_en = sr_q && MultiWin;
          exp_d   = exp_next;
          total_d = total_inc;
          now_d   = NowW'(1);
          outc_d  = OUTCOME_DELIVERED;
        end else if (in_window) begin
          buf_cmd_o.wr_en   = 1'b1;
          buf_cmd_o.wr_data = 1'b1;
          buf_waddr_o       = seq_idx;
          outc_d            = OUTCOME_BUFFERED;
          if (!nak_rdata_i) begin
            nak_cmd_o.wr_en   = 1'b1;
            nak_cmd_o.wr_data = 1'b1;
            kind_d            = KIND_NAK;
          end
        end else begin
          outc_d = OUTCOME_DISCARDED;
        end
      end
      ST_WALK: begin
        if (buf_rdata_i) begin
          buf_cmd_o.wr_en = 1'b1;
          nak_cmd_o.wr_en = 1'b1;
          buf_cmd_o.rd_en = walk_more;
          exp_d   = exp_next;
          total_d = total_inc;
          now_d   = now_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign buf_raddr_o = exp_next;
  assign nak_addr_o  = exp_q;

  always_comb begin
    rvalid_d = rvalid_q && !reply_o.ready;
    rkind_d  = rkind_q;
    rnum_d   = rnum_q;
    routc_d  = routc_q;
    rnow_d   = rnow_q;
    rtotal_d = rtotal_q;
    if (reply_load) begin
      rvalid_d = 1'b1;
      rkind_d  = kind_q;
      rnum_d   = (kind_q == KIND_NAK) ? NUM_W'(exp_q) : NUM_W'(ack_num);
      routc_d  = outc_q;
      rnow_d   = (32'(now_q) > 32'(NOW_MAX)) ? NOW_MAX : NOW_W'(now_q);
      rtotal_d = total_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      exp_q    <= '0;
      total_q  <= '0;
      now_q    <= '0;
      rvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      exp_q    <= exp_d;
      total_q  <= total_d;
      now_q    <= now_d;
      rvalid_q <= rvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q    <= seq_d;
    sr_q     <= sr_d;
    kind_q   <= kind_d;
    outc_q   <= outc_d;
    rkind_q  <= rkind_d;
    rnum_q   <= rnum_d;
    routc_q  <= routc_d;
    rnow_q   <= rnow_d;
    rtotal_q <= rtotal_d;
  end

  assign frame_i.ready           = (state_q == ST_IDLE);
  assign reply_o.valid           = rvalid_q;
  assign reply_o.reply_kind      = rkind_q;
  assign reply_o.reply_number    = rnum_q;
  assign reply_o.arrival_outcome = routc_q;
  assign reply_o.delivered_now   = rnow_q;
  assign reply_o.total_delivered = rtotal_q;

  `SWARQ_ASSERT(a_now_bounded, (32'(now_q) <= WINDOW), "Delivery run exceeds the window")
  `SWARQ_ASSERT(a_walk_sr_only, (state_q == ST_WALK) |-> sr_q,
                "Buffered run walked outside selective repeat")
  `SWARQ_ASSERT(a_exp_hold,
                !((state_q == ST_LOOKUP) || (state_q == ST_WALK)) |=> $stable(exp_q),
                "Expected number moved without a delivery")
  `SWARQ_ASSERT(a_mark_write_state,
                (buf_cmd_o.wr_en || nak_cmd_o.wr_en) |->
                  ((state_q == ST_LOOKUP) || (state_q == ST_WALK)),
                "Mark write outside lookup or walk")

endmodule
